### rtl/quaternion_smallest_three_decompress_core_assert.svh
// Assertion macros for the smallest-three quaternion decompressor.
// Used by the top level only; expects clk and rst_n in the enclosing scope.
`ifndef QUATERNION_SMALLEST_THREE_DECOMPRESS_CORE_ASSERT_SVH
`define QUATERNION_SMALLEST_THREE_DECOMPRESS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define QS3D_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked at every rising edge out of reset.
`define QS3D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QS3D_ASSERT(label, ante, cons, msg)
`define QS3D_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/qs3d_pkg.sv
// Shared constants, types and elaboration helpers for the quaternion decompressor.
// No dependencies.
`timescale 1ns / 1ps

package qs3d_pkg;

    localparam int WORD_W            = 32;
    localparam int IDX_W             = 2;
    localparam int IDX_SHIFT         = 30;
    localparam int NUM_COMPS         = 4;
    localparam int NUM_SMALL         = 3;
    localparam int COMP_W            = 16;
    localparam int COMP_MAX          = 32767;
    localparam int COMP_MIN          = -32768;
    localparam int MAG_BITS_DEF      = 9;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH       = 4;

    typedef logic [IDX_W-1:0] comp_idx_t;

    // Squared norm of a unit quaternion in magnitude units: 2 * (2^mag_bits - 1)^2.
    function automatic int norm_den(input int mag_bits);
        int mag_max;
        mag_max = (1 << mag_bits) - 1;
        return 2 * mag_max * mag_max;
    endfunction

    // Width that holds any root operand (a square, or the norm minus the sum of squares).
    function automatic int num_width(input int mag_bits);
        return 2 * mag_bits + 1;
    endfunction

endpackage

### rtl/qs3d_front.sv
// Front end: accepts a packed word, unpacks the three small components,
// squares them and forms the four root operands. Depends on qs3d_pkg.
`timescale 1ns / 1ps

module qs3d_front
    import qs3d_pkg::*;
#(
    parameter int MAG_BITS = MAG_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        word_valid,
    output logic                                        word_stall,
    input  logic [WORD_W-1:0]                           packed_word,
    output logic                                        q_wr,
    output logic [NUM_COMPS*(num_width(MAG_BITS)+1):0]  q_data,
    input  logic                                        q_full
);

    localparam int FLD_W = MAG_BITS + 1;
    localparam int NUM_W = num_width(MAG_BITS);
    localparam int SQ_W  = 2 * MAG_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int DEN   = norm_den(MAG_BITS);
    localparam int EXT_W = WORD_W + FLD_W;

    logic [EXT_W-1:0]     word_ext;
    comp_idx_t            big_idx;
    logic [FLD_W-1:0]     fld [NUM_SMALL];
    logic [SQ_W-1:0]      sq_next [NUM_COMPS];
    logic [NUM_COMPS-1:0] neg_next;
    logic                 advance;

    logic                 vld_reg;
    logic [SQ_W-1:0]      sq_reg [NUM_COMPS];
    logic [NUM_COMPS-1:0] neg_reg;
    comp_idx_t            big_reg;

    logic [SUM_W-1:0]     ssum;
    logic                 ovf;
    logic [NUM_W-1:0]     num_big;
    logic [NUM_W-1:0]     num [NUM_COMPS];

    // Bits above the word read as zero when the fields run past bit 31.
    assign word_ext = {{FLD_W{1'b0}}, packed_word};
    assign big_idx  = packed_word[IDX_SHIFT +: IDX_W];

    always_comb
    begin
        for (int j = 0; j < NUM_SMALL; j++)
        begin
            fld[j] = word_ext[j*FLD_W +: FLD_W];
        end
    end

    // Fields are packed from the low end for components 3 down to 0,
    // skipping the largest one.
    always_comb
    begin : p_unpack
        comp_idx_t        slot;
        logic [FLD_W-1:0] sel;
        for (int i = 0; i < NUM_COMPS; i++)
        begin
            slot = comp_idx_t'(NUM_COMPS - 1 - i) - comp_idx_t'(big_idx > comp_idx_t'(i));
            case (slot)
                comp_idx_t'(0): sel = fld[0];
                comp_idx_t'(1): sel = fld[1];
                comp_idx_t'(2): sel = fld[2];
                default:        sel = '0;
            endcase
            if (comp_idx_t'(i) == big_idx)
            begin
                sel = '0;
            end
            neg_next[i] = sel[MAG_BITS];
            sq_next[i]  = SQ_W'(sel[MAG_BITS-1:0]) * SQ_W'(sel[MAG_BITS-1:0]);
        end
    end

    assign advance    = !vld_reg || !q_full;
    assign word_stall = vld_reg && q_full;
    assign q_wr       = vld_reg && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg <= word_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_reg  <= sq_next;
            neg_reg <= neg_next;
            big_reg <= big_idx;
        end
    end

    // The largest component's square is zero, so summing all four is safe.
    always_comb
    begin
        ssum = '0;
        for (int i = 0; i < NUM_COMPS; i++)
        begin
            ssum = ssum + SUM_W'(sq_reg[i]);
        end
        ovf     = ssum > SUM_W'(DEN);
        num_big = ovf ? '0 : NUM_W'(SUM_W'(DEN) - ssum);
        for (int i = 0; i < NUM_COMPS; i++)
        begin
            num[i] = (comp_idx_t'(i) == big_reg) ? num_big : NUM_W'(sq_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_COMPS; i++)
        begin
            q_data[i*NUM_W +: NUM_W] = num[i];
        end
        q_data[NUM_COMPS*NUM_W +: NUM_COMPS] = neg_reg;
        q_data[NUM_COMPS*(NUM_W+1)]          = ovf;
    end

endmodule

### rtl/qs3d_queue.sv
// Small first-in first-out queue between the front end and the root pipeline.
// Depends on qs3d_pkg for the default depth.
`timescale 1ns / 1ps

module qs3d_queue
    import qs3d_pkg::*;
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);

    localparam int AW = $clog2(DEPTH);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW:0]       wr_ptr_reg;
    logic [AW:0]       rd_ptr_reg;

    assign empty   = wr_ptr_reg == rd_ptr_reg;
    assign full    = (wr_ptr_reg[AW] != rd_ptr_reg[AW]) &&
                     (wr_ptr_reg[AW-1:0] == rd_ptr_reg[AW-1:0]);
    assign rd_data = mem_reg[rd_ptr_reg[AW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + (AW+1)'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg[AW-1:0]] <= wr_data;
        end
    end

endmodule

### rtl/qs3d_root.sv
// Pipelined root unit: round(2^F * sqrt(num / den)), one result bit per stage,
// with den the squared unit norm. Depends on qs3d_pkg.
`timescale 1ns / 1ps

module qs3d_root
    import qs3d_pkg::*;
#(
    parameter int MAG_BITS      = MAG_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          en,
    input  logic [num_width(MAG_BITS)-1:0] num,
    output logic [OUT_FRAC_BITS:0]        root
);

    localparam int NUM_W  = num_width(MAG_BITS);
    localparam int DEN    = norm_den(MAG_BITS);
    localparam int STAGES = OUT_FRAC_BITS + 2;
    localparam int T_W    = OUT_FRAC_BITS + 2;
    localparam int PRE_SH = 2 * OUT_FRAC_BITS + 2;
    localparam int W      = NUM_W + PRE_SH + 1;

    // Each stage keeps the remainder num*2^PRE_SH - den*t^2 and den*t, so the
    // trial for the next bit needs only shifts, one add and one compare.
    logic [W-1:0]         r_reg  [STAGES-1];
    logic [W-1:0]         dt_reg [STAGES-1];
    logic [T_W-1:0]       t_reg  [STAGES];
    logic [OUT_FRAC_BITS:0] root_reg;
    logic [T_W-1:0]       round_sum;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        localparam int B = STAGES - 1 - k;

        logic [W-1:0]   r_in;
        logic [W-1:0]   dt_in;
        logic [T_W-1:0] t_in;
        logic [W-1:0]   trial;
        logic [W:0]     diff;
        logic           take;
        logic [T_W-1:0] t_next;

        if (k == 0)
        begin : g_first
            assign r_in  = W'(num) << PRE_SH;
            assign dt_in = '0;
            assign t_in  = '0;
        end
        else
        begin : g_chain
            assign r_in  = r_reg[k-1];
            assign dt_in = dt_reg[k-1];
            assign t_in  = t_reg[k-1];
        end

        assign trial  = (dt_in << (B + 1)) + (W'(DEN) << (2 * B));
        assign diff   = {1'b0, r_in} - {1'b0, trial};
        assign take   = !diff[W];
        assign t_next = take ? (t_in | (T_W'(1) << B)) : t_in;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                t_reg[k] <= t_next;
            end
        end

        if (k < STAGES - 1)
        begin : g_keep
            logic [W-1:0] r_next;
            logic [W-1:0] dt_next;

            assign r_next  = take ? diff[W-1:0] : r_in;
            assign dt_next = take ? (dt_in + (W'(DEN) << B)) : dt_in;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]  <= r_next;
                    dt_reg[k] <= dt_next;
                end
            end
        end
    end

    // t carries one extra fraction bit; add half and drop it.
    assign round_sum = t_reg[STAGES-1] + T_W'(1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= round_sum[T_W-1:1];
        end
    end

    assign root = root_reg;

endmodule

### rtl/qs3d_back.sv
// Back end: pops root operands from the queue, runs four root units in step,
// applies signs, saturates and holds the result item. Depends on qs3d_pkg, qs3d_root.
`timescale 1ns / 1ps

module qs3d_back
    import qs3d_pkg::*;
#(
    parameter int MAG_BITS      = MAG_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_empty,
    output logic                                        q_rd,
    input  logic [NUM_COMPS*(num_width(MAG_BITS)+1):0]  q_data,
    output logic                                        quat_valid,
    input  logic                                        quat_stall,
    output logic signed [COMP_W-1:0]                    comp [NUM_COMPS],
    output logic                                        norm_overflow
);

    localparam int NUM_W = num_width(MAG_BITS);
    localparam int LAT   = OUT_FRAC_BITS + 3;
    localparam int RT_W  = OUT_FRAC_BITS + 1;
    localparam int SW    = (RT_W + 1 > COMP_W + 1) ? RT_W + 1 : COMP_W + 1;

    logic                     en;
    logic [RT_W-1:0]          root [NUM_COMPS];
    logic [LAT-1:0]           vld_reg;
    logic [NUM_COMPS-1:0]     neg_pipe_reg [LAT];
    logic [LAT-1:0]           ovf_pipe_reg;
    logic signed [COMP_W-1:0] comp_next [NUM_COMPS];
    logic                     quat_valid_reg;
    logic signed [COMP_W-1:0] comp_reg [NUM_COMPS];
    logic                     ovf_reg;

    // The whole pipeline moves together unless a finished item is held.
    assign en   = !(quat_valid_reg && quat_stall);
    assign q_rd = en && !q_empty;

    for (genvar c = 0; c < NUM_COMPS; c++)
    begin : g_root
        qs3d_root #(
            .MAG_BITS      (MAG_BITS),
            .OUT_FRAC_BITS (OUT_FRAC_BITS)
        ) u_root (
            .clk  (clk),
            .en   (en),
            .num  (q_data[c*NUM_W +: NUM_W]),
            .root (root[c])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            quat_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg        <= {vld_reg[LAT-2:0], !q_empty};
            quat_valid_reg <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_pipe_reg[0] <= q_data[NUM_COMPS*NUM_W +: NUM_COMPS];
            for (int k = 1; k < LAT; k++)
            begin
                neg_pipe_reg[k] <= neg_pipe_reg[k-1];
            end
            ovf_pipe_reg <= {ovf_pipe_reg[LAT-2:0], q_data[NUM_COMPS*(NUM_W+1)]};
        end
    end

    always_comb
    begin : p_sign
        logic signed [SW-1:0] mag_s;
        logic signed [SW-1:0] val_s;
        for (int c = 0; c < NUM_COMPS; c++)
        begin
            mag_s = signed'(SW'(root[c]));
            val_s = neg_pipe_reg[LAT-1][c] ? -mag_s : mag_s;
            if (val_s > SW'(COMP_MAX))
            begin
                val_s = SW'(COMP_MAX);
            end
            else if (val_s < SW'(COMP_MIN))
            begin
                val_s = SW'(COMP_MIN);
            end
            comp_next[c] = signed'(val_s[COMP_W-1:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            comp_reg <= comp_next;
            ovf_reg  <= ovf_pipe_reg[LAT-1];
        end
    end

    assign quat_valid    = quat_valid_reg;
    assign comp          = comp_reg;
    assign norm_overflow = ovf_reg;

endmodule

### rtl/quaternion_smallest_three_decompress_core.sv
// Smallest-three quaternion decompressor, top level. Uses qs3d_pkg, qs3d_front, qs3d_queue, qs3d_back.
// Throughput is one item per cycle while quat_stall is low; the root units resolve one result bit per pipeline stage.
// Reset (rst_n, asynchronous, active low) empties the pipeline and the queue; no clearing pass
// is needed, so an item can be accepted as soon as reset is released.
`timescale 1ns / 1ps

`include "quaternion_smallest_three_decompress_core_assert.svh"

module quaternion_smallest_three_decompress_core
    import qs3d_pkg::*;
#(
    parameter int MAG_BITS      = MAG_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     word_valid,
    output logic                     word_stall,
    input  logic [WORD_W-1:0]        packed_word,
    output logic                     quat_valid,
    input  logic                     quat_stall,
    output logic signed [COMP_W-1:0] comp_0,
    output logic signed [COMP_W-1:0] comp_1,
    output logic signed [COMP_W-1:0] comp_2,
    output logic signed [COMP_W-1:0] comp_3,
    output logic                     norm_overflow
);

    // Queue entry: four root operands, four sign bits and the overflow flag.
    localparam int Q_W = NUM_COMPS * (num_width(MAG_BITS) + 1) + 1;

    logic                     q_wr;
    logic [Q_W-1:0]           q_wr_data;
    logic                     q_full;
    logic                     q_pop;
    logic [Q_W-1:0]           q_rd_data;
    logic                     q_empty;
    logic signed [COMP_W-1:0] comp_arr [NUM_COMPS];

    // The front end takes a word whenever its single holding stage is free or
    // can drain into the queue. It unpacks the index and the three sign-magnitude
    // fields, squares the magnitudes and works out the operand for the largest
    // component (the norm minus the sum of squares, or zero on overflow).
    qs3d_front #(
        .MAG_BITS (MAG_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .packed_word (packed_word),
        .q_wr        (q_wr),
        .q_data      (q_wr_data),
        .q_full      (q_full)
    );

    // The queue lets the front keep accepting words until it fills while the
    // result side is stalled, and lets the back end drain while input is idle.
    qs3d_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // The back end runs four root pipelines side by side, then applies the
    // signs and saturates into the output register. It freezes only while a
    // finished item sits unaccepted in that register.
    qs3d_back #(
        .MAG_BITS      (MAG_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_rd          (q_pop),
        .q_data        (q_rd_data),
        .quat_valid    (quat_valid),
        .quat_stall    (quat_stall),
        .comp          (comp_arr),
        .norm_overflow (norm_overflow)
    );

    assign comp_0 = comp_arr[0];
    assign comp_1 = comp_arr[1];
    assign comp_2 = comp_arr[2];
    assign comp_3 = comp_arr[3];

    // The front must never push into a full queue.
    `QS3D_ASSERT(a_no_write_when_full, q_wr, !q_full, "queue written while full")
    // Input back-pressure comes only from a full queue.
    `QS3D_ASSERT(a_stall_only_when_full, word_stall, q_full, "input stalled with queue space")
    // A full queue stays full until the back end pops.
    `QS3D_ASSERT_NEXT(a_full_holds, q_full && !q_pop, q_full, "full queue drained without pop")
    // On overflow the largest component is forced to zero.
    `QS3D_ASSERT(a_overflow_zero, quat_valid && norm_overflow,
        comp_0 == '0 || comp_1 == '0 || comp_2 == '0 || comp_3 == '0,
        "overflow item without a zero component")

endmodule
